// ----- src/cfir_pkg.sv -----
`default_nettype none

package cfir_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int TAP_INDEX_BITS = 6;
    localparam int TAP_COUNT_BITS = 7;
    localparam int OUT_SHIFT_BITS = 5;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    // Defaults for the top-level parameters
    localparam int MAX_TAPS_DEF = 64;
    localparam int ACC_BITS_DEF = 40;

    // Register reset values
    localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RST = TAP_COUNT_BITS'(1);
    localparam logic [OUT_SHIFT_BITS-1:0] OUT_SHIFT_RST = OUT_SHIFT_BITS'(15);

    // Item actions
    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_FILTER = 1'b1
    } action_t;

    // Register indexes (paddr word select)
    typedef enum logic {
        REG_TAP_COUNT = 1'b0,
        REG_OUT_SHIFT = 1'b1
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t re;
        sample_t im;
    } cplx_t;

    typedef struct packed {
        logic                      action;
        logic [TAP_INDEX_BITS-1:0] tap_index;
        sample_t                   tap_value;
        sample_t                   sample_re;
        sample_t                   sample_im;
        logic                      last_sample;
    } in_item_t;

    typedef struct packed {
        sample_t out_re;
        sample_t out_im;
        logic    overflow;
        logic    run_end;
    } out_item_t;

    // Delay-line control shared by every cell
    typedef struct packed {
        logic push;
        logic clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/cfir_cell.sv -----
`default_nettype none

module cfir_cell #(
    parameter int ACC_BITS = cfir_pkg::ACC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cfir_pkg::cell_ctl_t            ctl,
    input  wire logic                           coef_we,
    input  wire cfir_pkg::sample_t              coef_wdata,
    input  wire cfir_pkg::cplx_t                hist_in,
    output cfir_pkg::cplx_t                     hist_out,
    input  wire logic signed [ACC_BITS-1:0]     psum_re_in,
    input  wire logic signed [ACC_BITS-1:0]     psum_im_in,
    output logic signed [ACC_BITS-1:0]          psum_re_out,
    output logic signed [ACC_BITS-1:0]          psum_im_out
);

    localparam int PROD_BITS = 2 * cfir_pkg::SAMPLE_BITS;

    cfir_pkg::sample_t             coef_reg;
    cfir_pkg::cplx_t               hist_reg;
    logic signed [PROD_BITS-1:0]   prod_re_reg;
    logic signed [PROD_BITS-1:0]   prod_im_reg;
    logic signed [ACC_BITS-1:0]    psum_re_reg;
    logic signed [ACC_BITS-1:0]    psum_im_reg;

    // Hold the coefficient and this cell's delay-line entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            hist_reg <= '0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_reg <= coef_wdata;
            end
            if (ctl.clear)
            begin
                hist_reg <= '0;
            end
            else if (ctl.push)
            begin
                hist_reg <= hist_in;
            end
        end
    end

    // Multiply, then add into the partial sum handed along the row
    always_ff @(posedge clk)
    begin
        prod_re_reg <= coef_reg * hist_reg.re;
        prod_im_reg <= coef_reg * hist_reg.im;
        psum_re_reg <= psum_re_in + ACC_BITS'(prod_re_reg);
        psum_im_reg <= psum_im_in + ACC_BITS'(prod_im_reg);
    end

    assign hist_out    = hist_reg;
    assign psum_re_out = psum_re_reg;
    assign psum_im_out = psum_im_reg;

endmodule

`default_nettype wire

// ----- src/cfir_finish.sv -----
`default_nettype none

module cfir_finish #(
    parameter int ACC_BITS = cfir_pkg::ACC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  load,
    input  wire logic signed [ACC_BITS-1:0]            sum_re,
    input  wire logic signed [ACC_BITS-1:0]            sum_im,
    input  wire logic [cfir_pkg::OUT_SHIFT_BITS-1:0]   shift,
    input  wire logic                                  run_end,
    output logic                                       free,
    output cfir_pkg::out_item_t                        out_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready
);

    localparam int SB = cfir_pkg::SAMPLE_BITS;
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO =
        {{(ACC_BITS-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic signed [ACC_BITS-1:0] shr_re;
    logic signed [ACC_BITS-1:0] shr_im;
    logic                       hi_re;
    logic                       lo_re;
    logic                       hi_im;
    logic                       lo_im;
    cfir_pkg::out_item_t        item_next;
    cfir_pkg::out_item_t        item_reg;
    logic                       valid_reg;

    // Scale down, then clamp to the sample range
    always_comb
    begin
        shr_re = sum_re >>> shift;
        shr_im = sum_im >>> shift;
        hi_re  = shr_re > SAT_HI;
        lo_re  = shr_re < SAT_LO;
        hi_im  = shr_im > SAT_HI;
        lo_im  = shr_im < SAT_LO;
        item_next.out_re   = hi_re ? SAT_HI[SB-1:0] : (lo_re ? SAT_LO[SB-1:0] : shr_re[SB-1:0]);
        item_next.out_im   = hi_im ? SAT_HI[SB-1:0] : (lo_im ? SAT_LO[SB-1:0] : shr_im[SB-1:0]);
        item_next.overflow = hi_re | lo_re | hi_im | lo_im;
        item_next.run_end  = run_end;
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign free      = !valid_reg || out_ready;
    assign out_data  = item_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ----- src/complex_fir_real_taps.sv -----
`default_nettype none

// Complex-sample FIR with real taps, full linear convolution per run.
// Items with action 0 load one coefficient. Items with action 1 push a
// complex sample into the delay line and give one result; a sample flagged
// last also gives tail results, one fewer than the tap count clamped to
// 1..MAX_TAPS, then the delay line is cleared (coefficients are kept).
// Products are registered, the partial sums ripple one cell per clock along
// the row of multiply-accumulate cells, the sum at the end of the active taps
// is selected into a register, then shifted and saturated into the output
// register. The next item is accepted once the last result of the current
// one has been loaded into the output register. tap_count and out_shift are
// set over the APB port at byte addresses 0 and 4; the user must set them
// only while the filter is idle, as the block itself does not enforce this.
module complex_fir_real_taps #(
    parameter int MAX_TAPS = cfir_pkg::MAX_TAPS_DEF,
    parameter int ACC_BITS = cfir_pkg::ACC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire cfir_pkg::in_item_t                    in_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    output cfir_pkg::out_item_t                        out_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [cfir_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [cfir_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [cfir_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                       pready
);

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int CW = $clog2(MAX_TAPS + 3);

    // Configuration registers
    logic [cfir_pkg::TAP_COUNT_BITS-1:0] tap_count_reg;
    logic [cfir_pkg::OUT_SHIFT_BITS-1:0] out_shift_reg;
    cfir_pkg::reg_idx_t                  reg_sel;
    logic                                cfg_we;

    // Sequencer
    cfir_pkg::state_t   state_reg;
    cfir_pkg::state_t   state_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [TW-1:0]      tail_reg;
    logic [TW-1:0]      tail_next;
    logic               last_reg;
    logic               last_next;
    logic [TW-1:0]      taps;
    logic               accept;
    logic               is_filter;
    logic               capture;
    logic               fin_load;
    logic               fin_free;
    logic               feed_zero;
    cfir_pkg::cell_ctl_t ctl;

    // Cell row
    cfir_pkg::cplx_t             hist_chain [0:MAX_TAPS];
    logic signed [ACC_BITS-1:0]  psum_re_chain [0:MAX_TAPS];
    logic signed [ACC_BITS-1:0]  psum_im_chain [0:MAX_TAPS];
    logic [MAX_TAPS-1:0]         coef_we;
    logic signed [ACC_BITS-1:0]  sum_re_reg;
    logic signed [ACC_BITS-1:0]  sum_im_reg;

    // APB register access
    assign pready  = 1'b1;
    assign reg_sel = cfir_pkg::reg_idx_t'(paddr[2]);
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= cfir_pkg::TAP_COUNT_RST;
            out_shift_reg <= cfir_pkg::OUT_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                cfir_pkg::REG_TAP_COUNT: tap_count_reg <= pwdata[cfir_pkg::TAP_COUNT_BITS-1:0];
                cfir_pkg::REG_OUT_SHIFT: out_shift_reg <= pwdata[cfir_pkg::OUT_SHIFT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            cfir_pkg::REG_TAP_COUNT: prdata = cfir_pkg::APB_DATA_BITS'(tap_count_reg);
            cfir_pkg::REG_OUT_SHIFT: prdata = cfir_pkg::APB_DATA_BITS'(out_shift_reg);
            default:                 prdata = '0;
        endcase
    end

    // Clamp the tap count to 1..MAX_TAPS
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = TW'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            taps = TW'(MAX_TAPS);
        end
        else
        begin
            taps = TW'(tap_count_reg);
        end
    end

    assign accept    = in_valid && in_ready;
    assign is_filter = in_data.action == cfir_pkg::ACT_FILTER;

    // Next state and control strobes
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tail_next  = tail_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        capture    = 1'b0;
        fin_load   = 1'b0;
        feed_zero  = 1'b0;
        ctl.push   = 1'b0;
        ctl.clear  = 1'b0;
        unique case (state_reg)
            cfir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && is_filter)
                begin
                    ctl.push   = 1'b1;
                    cnt_next   = '0;
                    last_next  = in_data.last_sample;
                    tail_next  = in_data.last_sample ? taps - TW'(1) : '0;
                    state_next = cfir_pkg::ST_RUN;
                end
            end
            cfir_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(taps) + CW'(1))
                begin
                    capture    = 1'b1;
                    state_next = cfir_pkg::ST_FIN;
                end
            end
            cfir_pkg::ST_FIN:
            begin
                if (fin_free)
                begin
                    fin_load = 1'b1;
                    if (tail_reg != '0)
                    begin
                        // advance the tail with a zero sample
                        feed_zero  = 1'b1;
                        ctl.push   = 1'b1;
                        tail_next  = tail_reg - TW'(1);
                        cnt_next   = '0;
                        state_next = cfir_pkg::ST_RUN;
                    end
                    else
                    begin
                        ctl.clear  = last_reg;
                        state_next = cfir_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = cfir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfir_pkg::ST_IDLE;
            cnt_reg   <= '0;
            tail_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tail_reg  <= tail_next;
            last_reg  <= last_next;
        end
    end

    // Pick the sum at the end of the active taps
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            sum_re_reg <= psum_re_chain[taps];
            sum_im_reg <= psum_im_chain[taps];
        end
    end

    // Feed the head of the delay line
    assign hist_chain[0] = feed_zero ? '0 : {in_data.sample_re, in_data.sample_im};

    assign psum_re_chain[0] = '0;
    assign psum_im_chain[0] = '0;

    // Row of multiply-accumulate cells
    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        assign coef_we[i] = accept && !is_filter && (int'(in_data.tap_index) == i);

        cfir_cell #(
            .ACC_BITS (ACC_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .coef_we     (coef_we[i]),
            .coef_wdata  (in_data.tap_value),
            .hist_in     (hist_chain[i]),
            .hist_out    (hist_chain[i+1]),
            .psum_re_in  (psum_re_chain[i]),
            .psum_im_in  (psum_im_chain[i]),
            .psum_re_out (psum_re_chain[i+1]),
            .psum_im_out (psum_im_chain[i+1])
        );
    end

    // Scale, saturate and hold the result
    cfir_finish #(
        .ACC_BITS (ACC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fin_load),
        .sum_re    (sum_re_reg),
        .sum_im    (sum_im_reg),
        .shift     (out_shift_reg),
        .run_end   (tail_reg == '0),
        .free      (fin_free),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
    import cfir_pkg::*;

    localparam int MAX_TAPS = MAX_TAPS_DEF;
    localparam int SETTLE   = MAX_TAPS + 8;
    localparam int HOLD_LEN = 300;
    localparam int LIMIT    = 8_000_000;
    localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    in_item_t in_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    out_item_t out_data;
    logic out_valid;
    logic out_ready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    // Filter state as the testbench tracks it
    sample_t coef_m [MAX_TAPS];
    sample_t hist_re_m [MAX_TAPS];
    sample_t hist_im_m [MAX_TAPS];
    logic [TAP_COUNT_BITS-1:0] taps_m = TAP_COUNT_RST;
    logic [OUT_SHIFT_BITS-1:0] shift_m = OUT_SHIFT_RST;

    in_item_t items_to_send [$];
    out_item_t outputs_due [$];
    out_item_t want_res;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cycles = 0;
    int hold_cycles = 0;
    logic hold_req = 1'b0;
    wire holding = hold_req && (hold_cycles < HOLD_LEN);

    complex_fir_real_taps u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    function automatic int eff_taps();
        if (taps_m == 0)
            return 1;
        if (taps_m > MAX_TAPS)
            return MAX_TAPS;
        return int'(taps_m);
    endfunction

    // Shift right (floor) and saturate; top bit flags saturation
    function automatic logic [SAMPLE_BITS:0] clamp(longint acc);
        longint v;
        v = acc >>> shift_m;
        if (v > SAT_HI)
            return {1'b1, sample_t'(SAT_HI)};
        if (v < SAT_LO)
            return {1'b1, sample_t'(SAT_LO)};
        return {1'b0, v[SAMPLE_BITS-1:0]};
    endfunction

    function automatic out_item_t fir_output(int n, logic run_done);
        longint acc_re;
        longint acc_im;
        logic ov_re;
        logic ov_im;
        out_item_t r;
        acc_re = 0;
        acc_im = 0;
        for (int i = 0; i < n; i++)
        begin
            acc_re += longint'(coef_m[i]) * longint'(hist_re_m[i]);
            acc_im += longint'(coef_m[i]) * longint'(hist_im_m[i]);
        end
        {ov_re, r.out_re} = clamp(acc_re);
        {ov_im, r.out_im} = clamp(acc_im);
        r.overflow = ov_re | ov_im;
        r.run_end = run_done;
        return r;
    endfunction

    function automatic void shift_in(sample_t re, sample_t im);
        for (int i = MAX_TAPS - 1; i > 0; i--)
        begin
            hist_re_m[i] = hist_re_m[i-1];
            hist_im_m[i] = hist_im_m[i-1];
        end
        hist_re_m[0] = re;
        hist_im_m[0] = im;
    endfunction

    // Work out the outputs that one accepted item causes
    function automatic void predict(in_item_t it);
        int n;
        n = eff_taps();
        if (it.action == ACT_LOAD)
        begin
            coef_m[it.tap_index] = it.tap_value;
            return;
        end
        shift_in(it.sample_re, it.sample_im);
        outputs_due.push_back(fir_output(n, !it.last_sample || n == 1));
        if (it.last_sample)
        begin
            // flush the tail, then clear the delay line
            for (int k = 1; k < n; k++)
            begin
                shift_in('0, '0);
                outputs_due.push_back(fir_output(n, k == n - 1));
            end
            foreach (hist_re_m[i])
            begin
                hist_re_m[i] = '0;
                hist_im_m[i] = '0;
            end
        end
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0: return sample_t'(SAT_LO);
            1: return sample_t'(SAT_HI);
            2: return sample_t'(int'($urandom_range(8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic in_item_t tap_item(int idx, sample_t val);
        in_item_t it;
        it.action = ACT_LOAD;
        it.tap_index = TAP_INDEX_BITS'(idx);
        it.tap_value = val;
        it.sample_re = sample_t'($urandom);
        it.sample_im = sample_t'($urandom);
        it.last_sample = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_item_t sample_item(sample_t re, sample_t im, logic last);
        in_item_t it;
        it.action = ACT_FILTER;
        it.tap_index = TAP_INDEX_BITS'($urandom);
        it.tap_value = sample_t'($urandom);
        it.sample_re = re;
        it.sample_im = im;
        it.last_sample = last;
        return it;
    endfunction

    // Mostly well-formed runs, with stray tap loads mixed in
    task automatic random_batch(int n_items);
        int made;
        int len;
        logic close_run;
        made = 0;
        while (made < n_items)
        begin
            case ($urandom_range(9))
                0:
                begin
                    items_to_send.push_back(tap_item($urandom_range(MAX_TAPS - 1),
                                                     rand_sample()));
                    made++;
                end
                1, 2:
                begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++)
                        items_to_send.push_back(tap_item($urandom_range(eff_taps() - 1),
                                                         rand_sample()));
                    made += len;
                end
                default:
                begin
                    len = $urandom_range(1, 6);
                    close_run = ($urandom_range(9) < 6);
                    for (int k = 0; k < len; k++)
                        items_to_send.push_back(sample_item(rand_sample(), rand_sample(),
                                                            close_run && k == len - 1));
                    made += len;
                end
            endcase
        end
    endtask

    // Wait until every item is taken and every output has come back
    task automatic drain();
        do
            @(negedge clk);
        while (items_to_send.size() != 0 || in_valid || outputs_due.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TAP_COUNT: taps_m = value[TAP_COUNT_BITS-1:0];
            REG_OUT_SHIFT: shift_m = value[OUT_SHIFT_BITS-1:0];
        endcase
        @(negedge clk);
    endtask

    // Offer items from the queue; hold valid and payload until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict(in_data);
            if (!in_valid || in_ready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= items_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Count the one long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (holding)
            hold_cycles <= hold_cycles + 1;
    end

    // Take outputs and compare against the oldest one due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outputs_due.size() == 0)
                begin
                    $error("output with none due: re %0d im %0d",
                           out_data.out_re, out_data.out_im);
                    errors++;
                end
                else
                begin
                    want_res = outputs_due.pop_front();
                    if (out_data.out_re !== want_res.out_re)
                    begin
                        $error("out_re: expected %0d, got %0d", want_res.out_re, out_data.out_re);
                        errors++;
                    end
                    if (out_data.out_im !== want_res.out_im)
                    begin
                        $error("out_im: expected %0d, got %0d", want_res.out_im, out_data.out_im);
                        errors++;
                    end
                    if (out_data.overflow !== want_res.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               want_res.overflow, out_data.overflow);
                        errors++;
                    end
                    if (out_data.run_end !== want_res.run_end)
                    begin
                        $error("run_end: expected %0b, got %0b",
                               want_res.run_end, out_data.run_end);
                        errors++;
                    end
                end
            end
            out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Give up on a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        int taps_val;
        int shift_val;
        send_pct = '{0, 78, 0, 35};
        recv_pct = '{0, 0, 78, 35};
        foreach (coef_m[i])
        begin
            coef_m[i] = '0;
            hist_re_m[i] = '0;
            hist_im_m[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: one tap, all coefficients zero
        items_to_send.push_back(sample_item(100, -100, 1'b0));
        items_to_send.push_back(tap_item(0, -32768));
        items_to_send.push_back(tap_item(MAX_TAPS - 1, 32767));
        items_to_send.push_back(sample_item(-32768, 32767, 1'b0));
        items_to_send.push_back(sample_item(32767, -32768, 1'b1));
        drain();

        // Zero tap count acts as one tap; no shift forces saturation
        write_reg(REG_TAP_COUNT, 0);
        write_reg(REG_OUT_SHIFT, 0);
        items_to_send.push_back(tap_item(1, 32767));
        items_to_send.push_back(sample_item(1, -1, 1'b0));
        items_to_send.push_back(sample_item(-32768, -32768, 1'b1));
        drain();

        // Tap count above the maximum clamps to the full line; widest shift
        write_reg(REG_TAP_COUNT, 127);
        write_reg(REG_OUT_SHIFT, 31);
        items_to_send.push_back(tap_item(2, -1));
        items_to_send.push_back(sample_item(32767, 32767, 1'b0));
        items_to_send.push_back(sample_item(-32768, -32768, 1'b1));
        drain();

        // Start a run at full length, then shorten it without a flush
        write_reg(REG_TAP_COUNT, MAX_TAPS);
        write_reg(REG_OUT_SHIFT, 16);
        items_to_send.push_back(sample_item(32767, -32768, 1'b0));
        items_to_send.push_back(sample_item(12345, -23456, 1'b0));
        drain();
        write_reg(REG_TAP_COUNT, 3);
        write_reg(REG_OUT_SHIFT, 15);
        items_to_send.push_back(tap_item(0, 16384));
        items_to_send.push_back(tap_item(1, -16384));
        items_to_send.push_back(tap_item(2, 32767));
        items_to_send.push_back(sample_item(-1, 1, 1'b0));
        items_to_send.push_back(sample_item(32767, -32768, 1'b1));
        items_to_send.push_back(sample_item(-32768, 32767, 1'b1));
        drain();

        // Random runs under each idling mix and several settings
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            for (int s = 0; s < 4; s++)
            begin
                drain();
                if (phase == 1 && s == 3)
                    taps_val = MAX_TAPS;
                else if (phase == 3 && s == 0)
                    taps_val = $urandom_range(MAX_TAPS + 1, 127);
                else
                    case ($urandom_range(7))
                        0: taps_val = 0;
                        1: taps_val = 1;
                        2: taps_val = $urandom_range(9, 16);
                        default: taps_val = $urandom_range(2, 6);
                    endcase
                case ($urandom_range(5))
                    0: shift_val = 0;
                    1: shift_val = 31;
                    2: shift_val = $urandom_range(1, 30);
                    default: shift_val = $urandom_range(13, 17);
                endcase
                write_reg(REG_TAP_COUNT, taps_val);
                write_reg(REG_OUT_SHIFT, shift_val);
                random_batch(19);
                // Back up the output side while items keep coming
                if (phase == 0 && s == 1)
                    hold_req = 1'b1;
            end
        end

        drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
